[sv/aalu8_pkg.sv]
// Package for the 8-bit accumulator ALU: operation codes and the
// control and status types shared by the top level and the mul/div unit.
// No dependencies.
`default_nettype none

package aalu8_pkg;

  localparam int unsigned OpW   = 5;
  localparam int unsigned ByteW = 8;

  typedef enum logic [OpW-1:0] {
    OP_NOP   = 5'd0,
    OP_ADD   = 5'd1,
    OP_ADDC  = 5'd2,
    OP_SUBB  = 5'd3,
    OP_MUL   = 5'd4,
    OP_DIV   = 5'd5,
    OP_AND   = 5'd6,
    OP_OR    = 5'd7,
    OP_XOR   = 5'd8,
    OP_CLRA  = 5'd9,
    OP_CPLA  = 5'd10,
    OP_RL    = 5'd11,
    OP_RLC   = 5'd12,
    OP_RR    = 5'd13,
    OP_RRC   = 5'd14,
    OP_SWAP  = 5'd15,
    OP_INCA  = 5'd16,
    OP_DECA  = 5'd17,
    OP_XCH   = 5'd18,
    OP_XCHD  = 5'd19,
    OP_MOVA  = 5'd20,
    OP_MOVB  = 5'd21,
    OP_CLRC  = 5'd22,
    OP_SETBC = 5'd23,
    OP_CPLC  = 5'd24,
    OP_CJNE  = 5'd25
  } op_e;

  // Command from the sequencer to the mul/div unit.
  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
  } md_ctl_t;

  // Status back from the mul/div unit.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ByteW-1:0] hi;
    logic [ByteW-1:0] lo;
  } md_sts_t;

endpackage

`default_nettype wire

[sv/aalu8_muldiv.sv]
// Iterative 8x8 multiply and 8/8 divide on one shared 10-bit adder.
// Depends on aalu8_pkg.
`default_nettype none

module aalu8_muldiv (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire aalu8_pkg::md_ctl_t ctl_i,
  output aalu8_pkg::md_sts_t      sts_o
);
  import aalu8_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             div_q, div_d;
  logic [ByteW-1:0] b_q, b_d;
  logic [ByteW-1:0] hi_q, hi_d;
  logic [ByteW-1:0] lo_q, lo_d;

  // Shared adder: add for multiply, trial subtract for divide.
  logic [ByteW+1:0] opx, opy, sum;

  always_comb begin
    if (div_q) begin
      opx = {1'b0, hi_q, lo_q[ByteW-1]};
      opy = {2'b00, b_q};
      sum = opx - opy;
    end else begin
      opx = {2'b00, hi_q};
      opy = lo_q[0] ? {2'b00, b_q} : '0;
      sum = opx + opy;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    b_d    = b_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = ctl_i.is_div;
      b_d    = ctl_i.b;
      hi_d   = '0;
      lo_d   = ctl_i.a;
    end else if (busy_q) begin
      if (div_q) begin
        if (!sum[ByteW+1]) begin
          hi_d = sum[ByteW-1:0];
          lo_d = {lo_q[ByteW-2:0], 1'b1};
        end else begin
          hi_d = {hi_q[ByteW-2:0], lo_q[ByteW-1]};
          lo_d = {lo_q[ByteW-2:0], 1'b0};
        end
      end else begin
        hi_d = sum[ByteW:1];
        lo_d = {sum[0], lo_q[ByteW-1:1]};
      end
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    b_q   <= b_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign sts_o.hi   = hi_q;
  assign sts_o.lo   = lo_q;

endmodule

`default_nettype wire

[sv/accumulator_alu_8bit_with_flags_top.sv]
// Single-cycle ops: the result word is valid right after the accept edge.
// MUL and DIV by a nonzero B run 8 shared-adder iterations, then the output load.
// Single-cycle ops take one word per cycle while the result output is not stalled;
// during a MUL/DIV the block takes no input until the mul/div adder loop finishes and loads the result.
// Reset (rst_ni low, asynchronous) clears A, B, CY, AC, OV and empties the output register.
// Depends on aalu8_pkg and aalu8_muldiv.
`default_nettype none

module accumulator_alu_8bit_with_flags_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input word.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] operand
  input  wire logic [4:0]  s_axis_tuser_i,   // [4:0] op
  // Result word.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] acc_out, [15:8] b_out, [16] carry_out, [17] aux_carry_out,
  // [18] overflow_out, [26:19] writeback_byte, [27] not_equal,
  // [28] acc_is_zero, [31:29] zero
  output logic [31:0]      m_axis_tdata_o
);
  import aalu8_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Architectural state.
  logic [ByteW-1:0] acc_q, acc_d;
  logic [ByteW-1:0] b_q, b_d;
  logic             cy_q, cy_d;
  logic             ac_q, ac_d;
  logic             ov_q, ov_d;

  // Output register.
  logic             ovld_q, ovld_d;
  logic [31:0]      odata_q, odata_d;

  md_ctl_t md_ctl;
  md_sts_t md_sts;

  aalu8_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (md_ctl),
    .sts_o  (md_sts)
  );

  logic             in_acc;
  logic             out_take;
  op_e              op;
  logic [ByteW-1:0] v;
  logic             load;
  logic [ByteW-1:0] wb;
  logic             ne;

  // Remember which long op runs and the operand byte it echoes back.
  logic             md_ctl_div_q;
  logic [ByteW-1:0] hold_v_q;

  // Adder and borrow terms for ADD, ADDC and SUBB.
  logic             cin;
  logic [ByteW:0]   add_full;
  logic [4:0]       add_low;
  logic [ByteW-1:0] add_sev;
  logic             sb3, sb7, sb8;

  assign op       = op_e'(s_axis_tuser_i);
  assign v        = s_axis_tdata_i;
  assign out_take = ovld_q && m_axis_tready_i;
  // Take a word only from idle, with the output register free or draining now.
  assign s_axis_tready_o = (state_q == S_IDLE) && (!ovld_q || m_axis_tready_i);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;

  assign cin      = (op == OP_ADD) ? 1'b0 : cy_q;
  assign add_full = {1'b0, acc_q} + {1'b0, v} + {{ByteW{1'b0}}, cin};
  assign add_low  = {1'b0, acc_q[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
  assign add_sev  = {1'b0, acc_q[6:0]} + {1'b0, v[6:0]} + {7'd0, cin};
  assign sb3      = {1'b0, acc_q[3:0]} < ({1'b0, v[3:0]} + {4'd0, cy_q});
  assign sb7      = {1'b0, acc_q[6:0]} < ({1'b0, v[6:0]} + {7'd0, cy_q});
  assign sb8      = {1'b0, acc_q} < ({1'b0, v} + {{ByteW{1'b0}}, cy_q});

  always_comb begin
    state_d       = state_q;
    acc_d         = acc_q;
    b_d           = b_q;
    cy_d          = cy_q;
    ac_d          = ac_q;
    ov_d          = ov_q;
    wb            = v;
    ne            = 1'b0;
    load          = 1'b0;
    md_ctl.start  = 1'b0;
    md_ctl.is_div = (op == OP_DIV);
    md_ctl.a      = acc_q;
    md_ctl.b      = b_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          load = 1'b1;
          case (op)
            OP_ADD, OP_ADDC: begin
              acc_d = add_full[ByteW-1:0];
              cy_d  = add_full[ByteW];
              ac_d  = add_low[4];
              ov_d  = add_sev[7] ^ add_full[ByteW];
            end
            OP_SUBB: begin
              acc_d = acc_q - v - {{(ByteW-1){1'b0}}, cy_q};
              cy_d  = sb8;
              ac_d  = sb3;
              ov_d  = sb7 ^ sb8;
            end
            OP_MUL: begin
              // Hand off to the shared unit; hold the result until it finishes.
              load         = 1'b0;
              md_ctl.start = 1'b1;
              state_d      = S_RUN;
            end
            OP_DIV: begin
              cy_d = 1'b0;
              if (b_q == '0) begin
                ov_d = 1'b1;
              end else begin
                load         = 1'b0;
                md_ctl.start = 1'b1;
                state_d      = S_RUN;
              end
            end
            OP_AND:   acc_d = acc_q & v;
            OP_OR:    acc_d = acc_q | v;
            OP_XOR:   acc_d = acc_q ^ v;
            OP_CLRA:  acc_d = '0;
            OP_CPLA:  acc_d = ~acc_q;
            OP_RL:    acc_d = {acc_q[6:0], acc_q[7]};
            OP_RLC: begin
              acc_d = {acc_q[6:0], cy_q};
              cy_d  = acc_q[7];
            end
            OP_RR:    acc_d = {acc_q[0], acc_q[7:1]};
            OP_RRC: begin
              acc_d = {cy_q, acc_q[7:1]};
              cy_d  = acc_q[0];
            end
            OP_SWAP:  acc_d = {acc_q[3:0], acc_q[7:4]};
            OP_INCA:  acc_d = acc_q + 8'd1;
            OP_DECA:  acc_d = acc_q - 8'd1;
            OP_XCH: begin
              wb    = acc_q;
              acc_d = v;
            end
            OP_XCHD: begin
              wb    = {v[7:4], acc_q[3:0]};
              acc_d = {acc_q[7:4], v[3:0]};
            end
            OP_MOVA:  acc_d = v;
            OP_MOVB:  b_d   = v;
            OP_CLRC:  cy_d  = 1'b0;
            OP_SETBC: cy_d  = 1'b1;
            OP_CPLC:  cy_d  = ~cy_q;
            OP_CJNE: begin
              ne   = (acc_q != v);
              cy_d = (acc_q < v);
            end
            default: ;  // unused codes act as nop
          endcase
        end
      end
      S_RUN: begin
        if (md_sts.done) begin
          // Quotient or low product to A, remainder or high product to B.
          load    = 1'b1;
          acc_d   = md_sts.lo;
          b_d     = md_sts.hi;
          cy_d    = 1'b0;
          ov_d    = md_ctl_div_q ? 1'b0 : (md_sts.hi != '0);
          wb      = hold_v_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (md_ctl.start) begin
      md_ctl_div_q <= md_ctl.is_div;
      hold_v_q     <= v;
    end
  end

  always_comb begin
    ovld_d  = ovld_q;
    odata_d = odata_q;
    if (out_take) begin
      ovld_d = 1'b0;
    end
    if (load) begin
      ovld_d  = 1'b1;
      odata_d = {3'b000, (acc_d == '0), ne, wb, ov_d, ac_d, cy_d, b_d, acc_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= '0;
      b_q     <= '0;
      cy_q    <= 1'b0;
      ac_q    <= 1'b0;
      ov_q    <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      b_q     <= b_d;
      cy_q    <= cy_d;
      ac_q    <= ac_d;
      ov_q    <= ov_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = odata_q;

  // The output register must be empty for the whole of a mul/div run.
  a_run_out_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> !ovld_q)
    else $error("output register busy during mul/div run");

  // The unit reports completion only while the sequencer waits for it.
  a_done_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_sts.done |-> (state_q == S_RUN))
    else $error("mul/div done outside of a run");

  // An accepted MUL starts the unit and moves the sequencer to the run state.
  a_mul_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser_i == OP_MUL)) |=> ((state_q == S_RUN) && md_sts.busy))
    else $error("mul did not start the shared unit");

  // A run never takes an input word.
  a_no_accept_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_sts.busy |-> !s_axis_tready_o)
    else $error("input accepted while the shared unit is busy");

endmodule

`default_nettype wire
